// File: rtl/sgw_pkg.sv
`default_nettype none

package sgw_pkg;

  // Field and state widths.
  localparam int WLEN_W = 11;   // window length, also the config register width
  localparam int GC_W   = 11;   // G/C count inside the window
  localparam int CNT_W  = 12;   // bases seen and windows done, both saturating
  localparam int SUM_W  = 48;   // rate accumulator
  localparam int RATE_W = 32;   // one rate table entry
  localparam int BIN_W  = 7;    // rate table index

  // Rate table depth and the percentage scale of the bin.
  localparam int RATE_BINS = 100;
  localparam int PCT       = 100;

  // Stream word widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  // Reciprocal of (window + 1): m = ceil(2^RECIP_K / d). With gc*100 below 2^18 and
  // d below 2^11, K = 29 makes floor(gc*100*m / 2^K) equal the exact quotient.
  localparam int RECIP_K  = 29;
  localparam int DIV_D_W  = 12;
  localparam int DVD_W    = RECIP_K + 1;
  localparam int DIV_CT_W = $clog2(DVD_W);
  localparam int RECIP_W  = 27;
  localparam int M100_W   = RECIP_W + 7;
  localparam int PROD_W   = GC_W + M100_W;

  // Input word kinds carried on tuser.
  typedef enum logic {
    ACT_BASE = 1'b0,
    ACT_LOAD = 1'b1
  } act_t;

endpackage

`default_nettype wire

// File: rtl/sgw_cell.sv
`default_nettype none

module sgw_cell (
  input  wire logic clk,
  input  wire logic shift_en,
  input  wire logic inject,
  input  wire logic new_bit,
  input  wire logic prev_bit,
  output logic      cell_q
);

  logic cell_r;

  // One history bit: it loads the new base where the window begins, otherwise it
  // takes its neighbor's bit on every counted base.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      cell_r <= inject ? new_bit : prev_bit;
    end
  end

  assign cell_q = cell_r;

endmodule

`default_nettype wire

// File: rtl/sgw_recip.sv
`default_nettype none

module sgw_recip
  import sgw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic                    busy,
  output logic [M100_W-1:0]       m100
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE
  } state_t;

  state_t              state_r;
  logic [DVD_W-1:0]    dvd_r;
  logic [DVD_W-1:0]    quo_r;
  logic [DIV_D_W-1:0]  rem_r;
  logic [DIV_D_W-1:0]  dsr_r;
  logic [DIV_CT_W-1:0] cnt_r;
  logic [M100_W-1:0]   m100_r;

  logic [DIV_D_W:0]    trial;
  logic                q_bit;
  logic [DIV_D_W-1:0]  rem_nxt;
  logic [DVD_W-1:0]    dvd_start;

  // Dividend 2^K + d - 1 gives the rounded-up quotient.
  assign dvd_start = (DVD_W'(1) << RECIP_K) + DVD_W'(divisor) - DVD_W'(1);

  // One restoring step: bring down one dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    q_bit = (trial >= {1'b0, dsr_r});
    if (q_bit) begin
      rem_nxt = DIV_D_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[DIV_D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      m100_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            dvd_r   <= dvd_start;
            dsr_r   <= divisor;
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
          rem_r <= rem_nxt;
          quo_r <= {quo_r[DVD_W-2:0], q_bit};
          cnt_r <= cnt_r + DIV_CT_W'(1);
          if (cnt_r == DIV_CT_W'(DVD_W - 1)) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          // Fold the percentage scale into the reciprocal.
          m100_r  <= M100_W'(quo_r[RECIP_W-1:0]) * M100_W'(PCT);
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign m100 = m100_r;

endmodule

`default_nettype wire

// File: rtl/sliding_gc_window_rate_sum.sv
`default_nettype none

// Sliding G/C window rate accumulator. Input words are either bases (tuser 0) or rate
// table loads (tuser 1); a base with tlast closes the region and yields one output word
// with the summed rate and the number of full windows. The window length is
// cfg_wr_data rounded down to a multiple of 5 and capped at the largest multiple of 5
// not above MAX_WINDOW; the base history lives in a chain of that many one-bit cells.
// Throughput is one word per cycle while in_tready is high. After a base with tlast
// the input pauses until the result has passed the four-stage sum pipeline and has
// been taken on the output side. After each cfg write the input pauses while a bit-serial
// divider forms the reciprocal of the window length plus one.
// A load affects only bases that arrive after it; table entries must be loaded before
// any full window can use them.
module sliding_gc_window_rate_sum
  import sgw_pkg::*;
#(
  parameter int MAX_WINDOW = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration: mean fragment length.
  input  wire logic                   cfg_wr_en,
  input  wire logic [WLEN_W-1:0]      cfg_wr_data,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // base_char, bin_index, rate_value, pad
  input  wire logic                   in_tuser,   // action
  input  wire logic                   in_tlast,   // last_base
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // span_sum, window_count, pad
);

  localparam int CAP = MAX_WINDOW - (MAX_WINDOW % 5);
  localparam int KW  = $clog2(CAP + 1);

  localparam logic [7:0] CH_UG = 8'h47;
  localparam logic [7:0] CH_UC = 8'h43;
  localparam logic [7:0] CH_LG = 8'h67;
  localparam logic [7:0] CH_LC = 8'h63;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Input word fields.
  logic [7:0]        base_char;
  logic [BIN_W-1:0]  bin_index;
  logic [RATE_W-1:0] rate_value;

  assign base_char  = in_tdata[7:0];
  assign bin_index  = in_tdata[14:8];
  assign rate_value = in_tdata[46:15];

  // Region state.
  logic [WLEN_W-1:0] w_r, w_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [GC_W-1:0]   gc_r, gc_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  wins_r, wins_nxt;

  // Pipeline stages.
  logic              v1_r, act1_r, last1_r, full1_r;
  logic [GC_W-1:0]   gc1_r;
  logic [CNT_W-1:0]  cnt1_r;
  logic [BIN_W-1:0]  idx1_r;
  logic [RATE_W-1:0] rate1_r;

  logic              v2_r, act2_r, last2_r, full2_r;
  logic [PROD_W-1:0] prod2_r;
  logic [CNT_W-1:0]  cnt2_r;
  logic [BIN_W-1:0]  idx2_r;
  logic [RATE_W-1:0] rate2_r;

  logic              v3_r, last3_r, full3_r;
  logic [CNT_W-1:0]  cnt3_r;
  logic [RATE_W-1:0] rd3_r;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [RATE_W-1:0] rate_mem [RATE_BINS];

  logic              in_acc, base_acc, counting, base_gc, gc_sub, full_nxt;
  logic              last_inflight, div_busy;
  logic [M100_W-1:0] m100;
  logic [CAP-1:0]    hist, chain_in;

  // Window length: mean rounded down to a multiple of 5 through a reciprocal multiply
  // by 13108 / 2^16, exact for every 11-bit mean, then capped to the chain length.
  logic [24:0]       mean_x;
  logic [WLEN_W-1:0] w_raw;

  always_comb begin
    mean_x = 25'(cfg_wr_data) * 25'(13108);
    w_raw  = WLEN_W'(mean_x[24:16]) * WLEN_W'(5);
    if (int'(w_raw) > CAP) begin
      w_nxt = WLEN_W'(CAP);
    end else begin
      w_nxt = w_raw;
    end
    k_nxt = KW'(CAP) - KW'(w_nxt);
  end

  // Reciprocal of (window + 1), formed after each register write.
  sgw_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_wr_en),
    .divisor (DIV_D_W'(w_nxt) + DIV_D_W'(1)),
    .busy    (div_busy),
    .m100    (m100)
  );

  // Handshake on the input side.
  assign last_inflight = (v1_r & last1_r) | (v2_r & last2_r) | (v3_r & last3_r);
  assign in_tready     = !div_busy && !last_inflight && !out_valid_r;
  assign in_acc        = in_tvalid & in_tready;
  assign base_acc      = in_acc & (in_tuser == ACT_BASE);
  assign counting      = base_acc & (w_r != '0);
  assign base_gc       = (base_char == CH_UG) || (base_char == CH_UC) ||
                         (base_char == CH_LG) || (base_char == CH_LC);

  // History chain: the new base enters at cell CAP - w and leaves at the far end
  // exactly w bases later.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = 1'b0;
    end else begin : g_body
      assign chain_in[i] = hist[i-1];
    end
    sgw_cell u_cell (
      .clk      (clk),
      .shift_en (counting),
      .inject   (k_r == KW'(i)),
      .new_bit  (base_gc),
      .prev_bit (chain_in[i]),
      .cell_q   (hist[i])
    );
  end

  // G/C count, bases seen and window count for the current base.
  always_comb begin
    gc_sub   = (seen_r >= CNT_W'(w_r)) & hist[CAP-1];
    gc_nxt   = gc_r - GC_W'(gc_sub) + GC_W'(base_gc);
    seen_nxt = (seen_r == CNT_MAX) ? seen_r : seen_r + CNT_W'(1);
    full_nxt = (seen_nxt >= CNT_W'(w_r));
    if (full_nxt && (wins_r != CNT_MAX)) begin
      wins_nxt = wins_r + CNT_W'(1);
    end else begin
      wins_nxt = wins_r;
    end
  end

  // Region state; a register write or the last base clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= '0;
      k_r    <= KW'(CAP);
      gc_r   <= '0;
      seen_r <= '0;
      wins_r <= '0;
    end else if (cfg_wr_en) begin
      w_r    <= w_nxt;
      k_r    <= k_nxt;
      gc_r   <= '0;
      seen_r <= '0;
      wins_r <= '0;
    end else if (base_acc && in_tlast) begin
      gc_r   <= '0;
      seen_r <= '0;
      wins_r <= '0;
    end else if (counting) begin
      gc_r   <= gc_nxt;
      seen_r <= seen_nxt;
      wins_r <= wins_nxt;
    end
  end

  // Stage 1: capture the word and this base's window outcome.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      full1_r <= 1'b0;
    end else begin
      v1_r    <= in_acc;
      last1_r <= base_acc & in_tlast;
      full1_r <= counting & full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act1_r  <= in_tuser;
    gc1_r   <= counting ? gc_nxt : gc_r;
    cnt1_r  <= counting ? wins_nxt : wins_r;
    idx1_r  <= bin_index;
    rate1_r <= rate_value;
  end

  // Stage 2: gc times the scaled reciprocal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      last2_r <= 1'b0;
      full2_r <= 1'b0;
    end else begin
      v2_r    <= v1_r;
      last2_r <= last1_r;
      full2_r <= full1_r;
    end
  end

  always_ff @(posedge clk) begin
    act2_r  <= act1_r;
    prod2_r <= PROD_W'(gc1_r) * PROD_W'(m100);
    cnt2_r  <= cnt1_r;
    idx2_r  <= idx1_r;
    rate2_r <= rate1_r;
  end

  // Stage 3: bin select and rate table access; loads write here so they stay in
  // order with the reads of earlier bases.
  logic [PROD_W-RECIP_K-1:0] bin_full;
  logic [BIN_W-1:0]          bin3;

  always_comb begin
    bin_full = prod2_r[PROD_W-1:RECIP_K];
    if (bin_full >= (PROD_W - RECIP_K)'(RATE_BINS)) begin
      bin3 = BIN_W'(RATE_BINS - 1);
    end else begin
      bin3 = bin_full[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && (act2_r == ACT_LOAD) && (idx2_r < BIN_W'(RATE_BINS))) begin
      rate_mem[idx2_r] <= rate2_r;
    end
    rd3_r <= rate_mem[bin3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      last3_r <= 1'b0;
      full3_r <= 1'b0;
    end else begin
      v3_r    <= v2_r;
      last3_r <= last2_r;
      full3_r <= full2_r;
    end
  end

  always_ff @(posedge clk) begin
    cnt3_r <= cnt2_r;
  end

  // Stage 4: saturating accumulate and result register.
  logic [SUM_W:0] sum_ext;

  always_comb begin
    sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(rd3_r);
    if (v3_r && full3_r) begin
      sum_nxt = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en || (v3_r && last3_r)) begin
        sum_r <= '0;
      end else begin
        sum_r <= sum_nxt;
      end
      if (v3_r && last3_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && last3_r) begin
      out_sum_r <= sum_nxt;
      out_cnt_r <= cnt3_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - SUM_W - CNT_W)'(0), out_cnt_r, out_sum_r};

`ifndef SYNTHESIS
  // Only one region result may be in flight or waiting at a time.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({v1_r & last1_r, v2_r & last2_r, v3_r & last3_r, out_valid_r}) <= 1)
    else $error("more than one region result in flight");

  // The G/C count never exceeds the window length.
  a_gc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    GC_W'(gc_r) <= GC_W'(w_r))
    else $error("G/C count above window length");

  // A result appears only right after the last base leaves the pipeline.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r && last3_r))
    else $error("result without a closing base");

  // No base is taken while the reciprocal is being formed.
  a_no_base_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |=> !v1_r || $past(cfg_wr_en) || !div_busy)
    else $error("word accepted during reciprocal update");
`endif

endmodule

`default_nettype wire
